@@ src/stl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, character codes and classifiers for the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W   = 2;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_DQ,
    MODE_SQ,
    MODE_LT,
    MODE_GT,
    MODE_EQ,
    MODE_BANG
  } stl_mode_e;

  typedef enum logic [2:0] {
    TOK_OPEN,
    TOK_CLOSE,
    TOK_QUOTED,
    TOK_OP,
    TOK_IDENT,
    TOK_END
  } tok_kind_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GT,
    OP_LT,
    OP_ASSIGN,
    OP_EQ,
    OP_LE,
    OP_GE,
    OP_NE
  } op_kind_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
    op_kind_e           op;
  } token_t;

  typedef struct packed {
    token_t [MAX_RES-1:0] tok;
    logic   [CNT_W-1:0]   cnt;
  } bundle_t;

  function automatic logic is_separator(input logic [7:0] c);
    return c inside {CH_SPACE, CH_CR, CH_FF, CH_LF, CH_TAB, CH_COMMA, CH_SEMI};
  endfunction

  function automatic logic is_breaking(input logic [7:0] c);
    return is_separator(c) ||
           (c inside {CH_LBRACE, CH_RBRACE, CH_HASH, CH_BANG, CH_EQ, CH_LT, CH_GT});
  endfunction

endpackage

@@ src/stl_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_core
// Lexer state and per-word decode: builds the tokens one text byte closes.
// ----------------------------------------------------------------------------
module stl_core
  import stl_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LINE_BITS   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output bundle_t    bundle_o
);

  typedef struct packed {
    logic                   vld;
    tok_kind_e              kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    op_kind_e               op;
  } cand_t;

  stl_mode_e              mode_q, mode_d, mode_mid;
  logic [OFFSET_BITS-1:0] tb_q, tb_d, tb_mid;
  logic [OFFSET_BITS-1:0] bo_q, bo_d, bo_nx;
  logic [LINE_BITS-1:0]   lc_q, lc_d, lc_mid;
  logic                   re_idle;
  cand_t [3:0]            cand;
  bundle_t                bundle;
  logic [CNT_W-1:0]       n;

  function automatic cand_t mk(input tok_kind_e kind, input logic [OFFSET_BITS-1:0] start,
                               input logic [OFFSET_BITS-1:0] len, input op_kind_e op,
                               input logic [LINE_BITS-1:0] line);
    cand_t c;
    c.vld   = 1'b1;
    c.kind  = kind;
    c.start = start;
    c.len   = len;
    c.line  = line;
    c.op    = op;
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] off32(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] line32(input logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

  always_comb begin
    mode_mid = mode_q;
    tb_mid   = tb_q;
    lc_mid   = lc_q;
    re_idle  = 1'b0;
    cand     = '0;
    bo_nx    = bo_q + OFFSET_BITS'(1);

    case (mode_q)
      MODE_COMMENT: begin
        if (byte_i == CH_CR || byte_i == CH_LF) re_idle = 1'b1;
      end
      MODE_IDENT: begin
        if (is_breaking(byte_i)) begin
          cand[0] = mk(TOK_IDENT, tb_q, bo_q - tb_q, OP_NONE, lc_q);
          re_idle = 1'b1;
        end
      end
      MODE_DQ, MODE_SQ: begin
        if (byte_i == CH_CR || byte_i == CH_LF ||
            byte_i == ((mode_q == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
          cand[0]  = mk(TOK_QUOTED, tb_q, bo_q - tb_q, OP_NONE, lc_q);
          mode_mid = MODE_IDLE;
        end
      end
      MODE_LT: begin
        if (byte_i == CH_GT) begin
          cand[0]  = mk(TOK_OP, tb_q, OFFSET_BITS'(2), OP_NE, lc_q);
          mode_mid = MODE_IDLE;
        end else if (byte_i == CH_EQ) begin
          cand[0]  = mk(TOK_OP, tb_q, OFFSET_BITS'(2), OP_LE, lc_q);
          mode_mid = MODE_IDLE;
        end else begin
          cand[0] = mk(TOK_OP, tb_q, OFFSET_BITS'(1), OP_LT, lc_q);
          re_idle = 1'b1;
        end
      end
      MODE_GT: begin
        if (byte_i == CH_EQ) begin
          cand[0]  = mk(TOK_OP, tb_q, OFFSET_BITS'(2), OP_GE, lc_q);
          mode_mid = MODE_IDLE;
        end else begin
          cand[0] = mk(TOK_OP, tb_q, OFFSET_BITS'(1), OP_GT, lc_q);
          re_idle = 1'b1;
        end
      end
      MODE_EQ: begin
        if (byte_i == CH_EQ) begin
          cand[0]  = mk(TOK_OP, tb_q, OFFSET_BITS'(2), OP_EQ, lc_q);
          mode_mid = MODE_IDLE;
        end else begin
          cand[0] = mk(TOK_OP, tb_q, OFFSET_BITS'(1), OP_ASSIGN, lc_q);
          re_idle = 1'b1;
        end
      end
      MODE_BANG: begin
        if (byte_i == CH_EQ) begin
          cand[0]  = mk(TOK_OP, tb_q, OFFSET_BITS'(2), OP_NE, lc_q);
          mode_mid = MODE_IDLE;
        end else if (is_breaking(byte_i)) begin
          cand[0] = mk(TOK_IDENT, tb_q, OFFSET_BITS'(1), OP_NONE, lc_q);
          re_idle = 1'b1;
        end else begin
          mode_mid = MODE_IDENT;
        end
      end
      default: re_idle = 1'b1;
    endcase

    // start a new token from idle
    if (re_idle) begin
      tb_mid   = bo_q;
      mode_mid = MODE_IDLE;
      if (is_separator(byte_i)) begin
        if (byte_i == CH_LF) lc_mid = lc_q + LINE_BITS'(1);
      end else begin
        case (byte_i)
          CH_HASH:   mode_mid = MODE_COMMENT;
          CH_LBRACE: cand[1] = mk(TOK_OPEN, bo_q, OFFSET_BITS'(1), OP_NONE, lc_q);
          CH_RBRACE: cand[1] = mk(TOK_CLOSE, bo_q, OFFSET_BITS'(1), OP_NONE, lc_q);
          CH_DQUOTE: begin
            mode_mid = MODE_DQ;
            tb_mid   = bo_nx;
          end
          CH_SQUOTE: begin
            mode_mid = MODE_SQ;
            tb_mid   = bo_nx;
          end
          CH_LT:     mode_mid = MODE_LT;
          CH_GT:     mode_mid = MODE_GT;
          CH_EQ:     mode_mid = MODE_EQ;
          CH_BANG:   mode_mid = MODE_BANG;
          default:   mode_mid = MODE_IDENT;
        endcase
      end
    end

    // close the pending token and add the end token at end of text
    if (last_i) begin
      case (mode_mid)
        MODE_IDENT: cand[2] = mk(TOK_IDENT, tb_mid, bo_nx - tb_mid, OP_NONE, lc_mid);
        MODE_DQ, MODE_SQ: begin
          cand[2] = mk(TOK_QUOTED, tb_mid, bo_nx - tb_mid, OP_NONE, lc_mid);
        end
        MODE_LT:    cand[2] = mk(TOK_OP, tb_mid, OFFSET_BITS'(1), OP_LT, lc_mid);
        MODE_GT:    cand[2] = mk(TOK_OP, tb_mid, OFFSET_BITS'(1), OP_GT, lc_mid);
        MODE_EQ:    cand[2] = mk(TOK_OP, tb_mid, OFFSET_BITS'(1), OP_ASSIGN, lc_mid);
        MODE_BANG:  cand[2] = mk(TOK_IDENT, tb_mid, OFFSET_BITS'(1), OP_NONE, lc_mid);
        default:    cand[2] = '0;
      endcase
      cand[3] = mk(TOK_END, bo_nx, '0, OP_NONE, lc_mid);
    end
  end

  // pack valid candidates into result slots
  always_comb begin
    bundle = '0;
    n      = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i].vld && n != CNT_W'(MAX_RES)) begin
        bundle.tok[n].kind   = cand[i].kind;
        bundle.tok[n].start  = off32(cand[i].start);
        bundle.tok[n].length = off32(cand[i].len);
        bundle.tok[n].line   = line32(cand[i].line);
        bundle.tok[n].op     = cand[i].op;
        n = n + CNT_W'(1);
      end
    end
    bundle.cnt = n;
  end

  assign bundle_o = bundle;

  always_comb begin
    mode_d = mode_q;
    tb_d   = tb_q;
    bo_d   = bo_q;
    lc_d   = lc_q;
    if (step_i) begin
      if (last_i) begin
        mode_d = MODE_IDLE;
        tb_d   = '0;
        bo_d   = '0;
        lc_d   = '0;
      end else begin
        mode_d = mode_mid;
        tb_d   = tb_mid;
        bo_d   = bo_nx;
        lc_d   = lc_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      tb_q   <= '0;
      bo_q   <= '0;
      lc_q   <= '0;
    end else begin
      mode_q <= mode_d;
      tb_q   <= tb_d;
      bo_q   <= bo_d;
      lc_q   <= lc_d;
    end
  end

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> mode_q == MODE_IDLE && bo_q == '0 && lc_q == '0 && tb_q == '0)
    else $error("lexer state not cleared after final byte");

  a_end_token_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_i |-> bundle_o.cnt != '0 && bundle_o.tok[bundle_o.cnt - CNT_W'(1)].kind == TOK_END)
    else $error("final byte does not close with end token");

endmodule

@@ src/stl_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_outq
// Result register: holds the tokens of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module stl_outq
  import stl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    accept_i,
  output token_t  tok_o,
  output logic    last_o
);

  token_t [MAX_RES-1:0] slots_q, slots_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 at_last;

  assign valid_o = cnt_q != '0;
  assign at_last = idx_q == cnt_q - CNT_W'(1);
  assign ready_o = !valid_o || (at_last && accept_i);
  assign tok_o   = slots_q[idx_q];
  assign last_o  = at_last;

  always_comb begin
    slots_d = slots_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    if (valid_o && accept_i) begin
      if (at_last) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + CNT_W'(1);
      end
    end
    if (load_i) begin
      slots_d = bundle_i.tok;
      cnt_d   = bundle_i.cnt;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> idx_q < cnt_q)
    else $error("result index beyond held count");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o && bundle_i.cnt != '0)
    else $error("result register overwritten");

endmodule

@@ src/script_token_lexer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_top
// Brace / key-value script lexer: one text byte per word in, one token per
// word out, each token closed by the byte that ends it.
// ----------------------------------------------------------------------------
// A byte is held in the input word register, its tokens in the result register.
// Throughput: one byte per cycle while bytes close at most one token and the
// receiver is ready; a byte that closes more holds the next until its last is taken.
// Reset clears both word registers, puts the lexer between tokens and sets
// the byte offset and line count to zero.
// ----------------------------------------------------------------------------
module script_token_lexer_top
  import stl_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LINE_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // [31:0] token_start, [63:32] token_length,
                                     // [95:64] line_number
  output logic [5:0]  m_axis_tuser,  // [2:0] token_kind, [5:3] operator_kind
  output logic        m_axis_tlast   // last_of_run
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       take;
  logic       oq_ready;
  bundle_t    bundle;
  token_t     tok;

  stl_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (take),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .bundle_o(bundle)
  );

  stl_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take && bundle.cnt != '0),
    .bundle_i(bundle),
    .ready_o (oq_ready),
    .valid_o (m_axis_tvalid),
    .accept_i(m_axis_tready),
    .tok_o   (tok),
    .last_o  (m_axis_tlast)
  );

  assign take          = in_vld_q && (bundle.cnt == '0 || oq_ready);
  assign s_axis_tready = !in_vld_q || take;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) in_vld_d = 1'b0;
    if (s_axis_tvalid && s_axis_tready) in_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tdata = {tok.line, tok.length, tok.start};
  assign m_axis_tuser = {tok.op, tok.kind};

  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tok.kind == TOK_END |-> m_axis_tlast)
    else $error("end token not last of its run");

  a_op_only_on_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tok.kind != TOK_OP |-> tok.op == OP_NONE)
    else $error("operator kind on non-operator token");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the script token lexer end to end. Script bytes go in as words on the
// slave stream. A token scoreboard keeps its own copy of the lexer state and
// works out the tokens that each accepted byte closes. Every token word on the
// master stream is compared field by field with the oldest token still owed.
// The bytes come from a short directed text and then from random texts built
// of identifiers, quotes, operators, braces, comments, separators and noise.
// Both sides idle at random, the receiver holds off once for a long stretch,
// and the sender pauses twice until every token has come out.
// ----------------------------------------------------------------------------
module testbench;
  import stl_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES   = 400;
  localparam int unsigned HOLD_CYCLES    = 120;

  typedef struct {
    token_t tok;
    logic   last;
  } owed_token_t;

  class token_scoreboard;
    stl_mode_e     mode;
    logic [31:0]   tok_begin;
    logic [31:0]   offset;
    logic [31:0]   line_cnt;
    token_t        closed[$];
    owed_token_t   owed[$];
    int unsigned   errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      mode      = MODE_IDLE;
      tok_begin = '0;
      offset    = '0;
      line_cnt  = '0;
    endfunction

    function bit separates(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
             (c == CH_FF) || (c == CH_COMMA) || (c == CH_SEMI);
    endfunction

    function bit ends_ident(logic [7:0] c);
      return separates(c) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
             (c == CH_HASH) || (c == CH_BANG) || (c == CH_EQ) ||
             (c == CH_LT) || (c == CH_GT);
    endfunction

    function void close_token(tok_kind_e k, logic [31:0] s, logic [31:0] len,
                              op_kind_e op);
      token_t t;
      t.kind   = k;
      t.start  = s;
      t.length = len;
      t.line   = line_cnt;
      t.op     = op;
      closed.push_back(t);
    endfunction

    function void scan_between(logic [7:0] c);
      mode      = MODE_IDLE;
      tok_begin = offset;
      if (separates(c)) begin
        if (c == CH_LF) line_cnt = line_cnt + 1;
      end else if (c == CH_HASH) begin
        mode = MODE_COMMENT;
      end else if (c == CH_LBRACE) begin
        close_token(TOK_OPEN, offset, 1, OP_NONE);
      end else if (c == CH_RBRACE) begin
        close_token(TOK_CLOSE, offset, 1, OP_NONE);
      end else if (c == CH_DQUOTE) begin
        mode      = MODE_DQ;
        tok_begin = offset + 1;
      end else if (c == CH_SQUOTE) begin
        mode      = MODE_SQ;
        tok_begin = offset + 1;
      end else if (c == CH_LT) begin
        mode = MODE_LT;
      end else if (c == CH_GT) begin
        mode = MODE_GT;
      end else if (c == CH_EQ) begin
        mode = MODE_EQ;
      end else if (c == CH_BANG) begin
        mode = MODE_BANG;
      end else begin
        mode = MODE_IDENT;
      end
    endfunction

    function void finish_pair(logic [7:0] c, op_kind_e op2, op_kind_e op1);
      if (c == CH_EQ) begin
        close_token(TOK_OP, tok_begin, 2, op2);
        mode = MODE_IDLE;
      end else begin
        close_token(TOK_OP, tok_begin, 1, op1);
        scan_between(c);
      end
    endfunction

    function void lex_byte(logic [7:0] c);
      case (mode)
        MODE_COMMENT: begin
          if (c == CH_CR || c == CH_LF) scan_between(c);
        end
        MODE_IDENT: begin
          if (ends_ident(c)) begin
            close_token(TOK_IDENT, tok_begin, offset - tok_begin, OP_NONE);
            scan_between(c);
          end
        end
        MODE_DQ, MODE_SQ: begin
          if (c == CH_CR || c == CH_LF ||
              c == ((mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
            close_token(TOK_QUOTED, tok_begin, offset - tok_begin, OP_NONE);
            mode = MODE_IDLE;
          end
        end
        MODE_LT: begin
          if (c == CH_GT) begin
            close_token(TOK_OP, tok_begin, 2, OP_NE);
            mode = MODE_IDLE;
          end else begin
            finish_pair(c, OP_LE, OP_LT);
          end
        end
        MODE_GT: finish_pair(c, OP_GE, OP_GT);
        MODE_EQ: finish_pair(c, OP_EQ, OP_ASSIGN);
        MODE_BANG: begin
          if (c == CH_EQ) begin
            close_token(TOK_OP, tok_begin, 2, OP_NE);
            mode = MODE_IDLE;
          end else if (ends_ident(c)) begin
            close_token(TOK_IDENT, tok_begin, 1, OP_NONE);
            scan_between(c);
          end else begin
            mode = MODE_IDENT;
          end
        end
        default: scan_between(c);
      endcase
    endfunction

    function void close_at_end();
      case (mode)
        MODE_IDENT:       close_token(TOK_IDENT, tok_begin, offset - tok_begin, OP_NONE);
        MODE_DQ, MODE_SQ: close_token(TOK_QUOTED, tok_begin, offset - tok_begin, OP_NONE);
        MODE_LT:          close_token(TOK_OP, tok_begin, 1, OP_LT);
        MODE_GT:          close_token(TOK_OP, tok_begin, 1, OP_GT);
        MODE_EQ:          close_token(TOK_OP, tok_begin, 1, OP_ASSIGN);
        MODE_BANG:        close_token(TOK_IDENT, tok_begin, 1, OP_NONE);
        default: ;
      endcase
      close_token(TOK_END, offset, 0, OP_NONE);
    endfunction

    function void note_byte(logic [7:0] c, logic final_byte);
      owed_token_t o;
      closed.delete();
      lex_byte(c);
      offset = offset + 1;
      if (final_byte) begin
        close_at_end();
        restart();
      end
      foreach (closed[i]) begin
        o.tok  = closed[i];
        o.last = (i == closed.size() - 1);
        owed.push_back(o);
      end
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_token(logic [95:0] data, logic [5:0] user, logic last);
      owed_token_t o;
      if (owed.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                 $time, user[2:0], data[31:0]);
        errors++;
        return;
      end
      o = owed.pop_front();
      compare("token_kind", 32'(o.tok.kind), 32'(user[2:0]));
      compare("token_start", o.tok.start, data[31:0]);
      compare("token_length", o.tok.length, data[63:32]);
      compare("line_number", o.tok.line, data[95:64]);
      compare("operator_kind", 32'(o.tok.op), 32'(user[5:3]));
      compare("last_of_run", 32'(o.last), 32'(last));
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;
  logic        m_axis_tlast;

  token_scoreboard sb = new();
  bit              quiet;
  int unsigned     bytes_sent;
  int unsigned     tokens_seen;
  int unsigned     hold_left;
  int unsigned     stuck_cycles;
  logic [7:0]      text_buf[$];

  script_token_lexer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        tokens_seen++;
        if (tokens_seen == 40) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer_byte(logic [7:0] b, logic final_byte);
    while (!quiet && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= final_byte;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b, final_byte);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit end_text);
    for (int i = 0; i < s.len(); i++) begin
      offer_byte(s[i], end_text && (i == s.len() - 1));
    end
  endtask

  // hold the sender until every owed token has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 6))
      0:       return CH_TAB;
      1:       return CH_CR;
      2:       return CH_LF;
      3:       return CH_FF;
      4:       return CH_COMMA;
      5:       return CH_SEMI;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void add_piece();
    int unsigned n;
    logic [7:0]  q;
    case ($urandom_range(0, 10))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(9) == 0) text_buf.push_back(CH_SQUOTE);
          else text_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
        end
      end
      2, 3: begin
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        text_buf.push_back(q);
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(3) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
          else text_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
        end
        case ($urandom_range(0, 5))
          0:       text_buf.push_back(CH_LF);
          1:       text_buf.push_back(CH_CR);
          2:       ;
          default: text_buf.push_back(q);
        endcase
      end
      4, 5: begin
        case ($urandom_range(0, 8))
          0: begin text_buf.push_back(CH_EQ);   text_buf.push_back(CH_EQ); end
          1: begin text_buf.push_back(CH_LT);   text_buf.push_back(CH_EQ); end
          2: begin text_buf.push_back(CH_GT);   text_buf.push_back(CH_EQ); end
          3: begin text_buf.push_back(CH_LT);   text_buf.push_back(CH_GT); end
          4: begin text_buf.push_back(CH_BANG); text_buf.push_back(CH_EQ); end
          5: text_buf.push_back(CH_LT);
          6: text_buf.push_back(CH_GT);
          7: text_buf.push_back(CH_EQ);
          default: text_buf.push_back(CH_BANG);
        endcase
      end
      6: text_buf.push_back(CH_LBRACE);
      7: text_buf.push_back(CH_RBRACE);
      8: begin
        text_buf.push_back(CH_HASH);
        n = $urandom_range(0, 6);
        repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
        text_buf.push_back($urandom_range(3) == 0 ? CH_CR : CH_LF);
      end
      9: text_buf.push_back(8'($urandom_range(0, 255)));
      default: text_buf.push_back(pick_separator());
    endcase
    if ($urandom_range(99) < 60) text_buf.push_back(pick_separator());
  endfunction

  task automatic send_random_text();
    int unsigned want;
    want = ($urandom_range(9) == 0) ? 1 : $urandom_range(3, 40);
    text_buf.delete();
    while (text_buf.size() < want) add_piece();
    foreach (text_buf[i]) offer_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    quiet  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("{a>=\"x\"}", 1'b0);
    send_text("<>!=!;#c\n", 1'b0);
    send_text("'q\r", 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h00, 1'b0);
    send_text("<", 1'b1);
    send_text("\"a\n>x=y'", 1'b1);
    drain();

    while (bytes_sent < RANDOM_BYTES + 30) begin
      quiet = (bytes_sent >= 150) && (bytes_sent < 260);
      if (!paused && bytes_sent >= 300) begin
        paused = 1'b1;
        drain();
      end
      send_random_text();
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
